>>> rtl/core/gvtc_pkg.sv
// package for the graph valid-tree checker: sizes, marks and verdict codes
// no dependencies
`default_nettype none
package gvtc_pkg;
  localparam int unsigned MaxNodesDef = 256;
  localparam int unsigned MaxEdgesDef = 512;
  localparam int unsigned NodeW       = 8;
  localparam int unsigned CountW      = 9;
  localparam int unsigned VerdictW    = 2;

  localparam logic [1:0] MarkUnseen = 2'd0;
  localparam logic [1:0] MarkOnPath = 2'd1;
  localparam logic [1:0] MarkDone   = 2'd2;

  localparam logic [VerdictW-1:0] VerdictTree     = 2'd0;
  localparam logic [VerdictW-1:0] VerdictCycle    = 2'd1;
  localparam logic [VerdictW-1:0] VerdictPartial  = 2'd2;
  localparam logic [VerdictW-1:0] VerdictEdgeFail = 2'd3;
endpackage
`default_nettype wire

>>> rtl/core/gvtc_ram.sv
// generic single-port-write ram with one registered read port
// no dependencies
`default_nettype none
module gvtc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/core/graph_valid_tree_check.sv
// graph valid-tree checker: edges go into adjacency lists, a check runs a dfs from node 0
// edge transfer: busy over two entry appends and two link fixups; bad edges raise no busy
// check: root setup, a read and mark per adjacency entry, a pop per finished node, then a
//   clearing sweep of MaxNodes nodes and a result; done_o pulses as busy drops, no stall
// reset: async active low, then a sweep of MaxNodes nodes empties the lists, busy high
// depends on gvtc_pkg and gvtc_ram
`default_nettype none
module graph_valid_tree_check
  import gvtc_pkg::*;
#(
  parameter int unsigned MaxNodes = MaxNodesDef,
  parameter int unsigned MaxEdges = MaxEdgesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                cfg_we_i,
  input  wire logic [CountW-1:0]   cfg_wdata_i,
  input  wire logic                kind_i,
  input  wire logic [NodeW-1:0]    node_a_i,
  input  wire logic [NodeW-1:0]    node_b_i,
  output logic                     done_o,
  output logic                     is_tree_o,
  output logic [VerdictW-1:0]      verdict_o,
  output logic [CountW-1:0]        nodes_reached_o
);
  localparam int unsigned NW  = $clog2(MaxNodes);       // node index bits
  localparam int unsigned EW  = $clog2(2 * MaxEdges);   // entry slot bits
  localparam int unsigned PW  = EW + 1;                 // slot or nil marker
  localparam int unsigned ECW = $clog2(MaxEdges + 1);   // edge counter bits
  localparam int unsigned SW  = $clog2(MaxNodes + 1);   // stack pointer bits
  localparam int unsigned CW  = $clog2(MaxNodes + 1);   // reached count bits
  localparam int unsigned FW  = NW + NW + 1 + PW;       // stack frame bits
  localparam logic [PW-1:0] Nil = {PW{1'b1}};

  typedef enum logic [3:0] {
    StClear, StIdle, StEdgeA, StEdgeLinkA, StEdgeB, StEdgeLinkB,
    StRoot, StRootW, StStep, StEntW, StMarkW, StHeadW, StPopW, StResult
  } state_e;

  state_e state_q;

  // memories
  logic           tgt_we, nxt_we, head_we, tail_we, mark_we, stk_we;
  logic [EW-1:0]  tgt_wa, nxt_wa, ent_ra;
  logic [NW-1:0]  tgt_wd, tgt_rd;
  logic [PW-1:0]  nxt_wd, nxt_rd, head_wd, head_rd, tail_wd, tail_rd;
  logic [NW-1:0]  head_wa, head_ra, tail_wa, tail_ra, mark_wa, mark_ra;
  logic [1:0]     mark_wd, mark_rd;
  logic [NW-1:0]  stk_wa, stk_ra;
  logic [FW-1:0]  stk_wd, stk_rd;

  gvtc_ram #(.Width(NW), .Depth(2 * MaxEdges)) u_tgt (.clk_i, .we_i(tgt_we), .waddr_i(tgt_wa),
    .wdata_i(tgt_wd), .raddr_i(ent_ra), .rdata_o(tgt_rd));
  gvtc_ram #(.Width(PW), .Depth(2 * MaxEdges)) u_nxt (.clk_i, .we_i(nxt_we), .waddr_i(nxt_wa),
    .wdata_i(nxt_wd), .raddr_i(ent_ra), .rdata_o(nxt_rd));
  gvtc_ram #(.Width(PW), .Depth(MaxNodes)) u_head (.clk_i, .we_i(head_we), .waddr_i(head_wa),
    .wdata_i(head_wd), .raddr_i(head_ra), .rdata_o(head_rd));
  gvtc_ram #(.Width(PW), .Depth(MaxNodes)) u_tail (.clk_i, .we_i(tail_we), .waddr_i(tail_wa),
    .wdata_i(tail_wd), .raddr_i(tail_ra), .rdata_o(tail_rd));
  gvtc_ram #(.Width(2), .Depth(MaxNodes)) u_mark (.clk_i, .we_i(mark_we), .waddr_i(mark_wa),
    .wdata_i(mark_wd), .raddr_i(mark_ra), .rdata_o(mark_rd));
  gvtc_ram #(.Width(FW), .Depth(MaxNodes)) u_stk (.clk_i, .we_i(stk_we), .waddr_i(stk_wa),
    .wdata_i(stk_wd), .raddr_i(stk_ra), .rdata_o(stk_rd));

  // control and scratch registers
  logic [CountW-1:0] node_count_q;
  logic [ECW-1:0]    edges_q;
  logic              err_q;
  logic [NW-1:0]     clr_q;
  logic              clr_after_q;     // sweep follows a check, emit result at its end
  logic [NW-1:0]     a_q, b_q;
  logic [PW-1:0]     tail_a_q, tail_b_q;
  logic [SW-1:0]     sp_q;            // frames on the stack, top frame held in registers
  logic [CW-1:0]     reached_q;
  logic [NW-1:0]     fnode_q, fpar_q, w_q;
  logic              fhas_q;
  logic [PW-1:0]     fcur_q;
  logic [VerdictW-1:0] verdict_q;

  logic          bad_edge;
  logic [EW-1:0] slot_a, slot_b;
  logic [PW-1:0] tail_b;
  logic [SW-1:0] sp_m1, sp_m2;
  logic          push_ok;

  assign bad_edge = (CountW'(node_a_i) >= node_count_q) ||
                    (CountW'(node_b_i) >= node_count_q) ||
                    (32'(node_a_i) >= MaxNodes) || (32'(node_b_i) >= MaxNodes) ||
                    (32'(edges_q) >= MaxEdges);

  assign slot_a = EW'({edges_q, 1'b0});
  assign slot_b = slot_a | EW'(1);

  // old tail of b; on a self-loop the entry just appended to a is that tail
  assign tail_b = (a_q == b_q) ? PW'(slot_a) : tail_rd;

  assign sp_m1 = sp_q - SW'(1);
  assign sp_m2 = sp_q - SW'(2);

  // neighbor is unseen and the stack has room
  assign push_ok = (mark_rd == MarkUnseen) && (32'(sp_q) < MaxNodes);

  assign busy = (state_q != StIdle);

  // memory port steering from state, registers, node_a_i in idle and the target read data
  always_comb begin
    tgt_we = 1'b0; nxt_we = 1'b0; head_we = 1'b0; tail_we = 1'b0;
    mark_we = 1'b0; stk_we = 1'b0;
    tgt_wa = slot_a; tgt_wd = b_q;
    nxt_wa = slot_a; nxt_wd = Nil;
    head_wa = a_q; head_wd = PW'(slot_a);
    tail_wa = a_q; tail_wd = PW'(slot_a);
    mark_wa = clr_q; mark_wd = MarkUnseen;
    stk_wa = NW'(sp_m1); stk_wd = {fnode_q, fpar_q, fhas_q, fcur_q};
    ent_ra = fcur_q[EW-1:0];
    head_ra = w_q; tail_ra = a_q; mark_ra = tgt_rd;
    stk_ra = NW'(sp_m2);
    case (state_q)
      StClear: begin
        head_we = 1'b1; head_wa = clr_q; head_wd = Nil;
        tail_we = 1'b1; tail_wa = clr_q; tail_wd = Nil;
        mark_we = 1'b1;
      end
      StIdle: begin
        tail_ra = NW'(node_a_i);
      end
      StEdgeA: begin
        // new entry for b at the end of the list of a; tail of b read
        tgt_we = 1'b1; nxt_we = 1'b1;
        tail_we = 1'b1;
        head_we = (tail_rd == Nil);
        tail_ra = b_q;
      end
      StEdgeLinkA: begin
        // entry for a, and link the old tail of a to the new entry
        tgt_we = 1'b1; tgt_wa = slot_b; tgt_wd = a_q;
        nxt_we = (tail_a_q != Nil); nxt_wa = tail_a_q[EW-1:0]; nxt_wd = PW'(slot_a);
      end
      StEdgeB: begin
        nxt_we = 1'b1; nxt_wa = slot_b; nxt_wd = Nil;
        tail_we = 1'b1; tail_wa = b_q; tail_wd = PW'(slot_b);
        head_we = (tail_b_q == Nil); head_wa = b_q; head_wd = PW'(slot_b);
      end
      StEdgeLinkB: begin
        nxt_we = (tail_b_q != Nil); nxt_wa = tail_b_q[EW-1:0]; nxt_wd = PW'(slot_b);
      end
      StRoot: begin
        mark_we = 1'b1; mark_wa = '0; mark_wd = MarkOnPath;
        head_ra = '0;
      end
      StStep: begin
        // list exhausted: the node is finished
        if (fcur_q == Nil) begin
          mark_we = 1'b1; mark_wa = fnode_q; mark_wd = MarkDone;
        end
      end
      StMarkW: begin
        // descend: save the current frame with its advanced cursor
        if (push_ok) begin
          mark_we = 1'b1; mark_wa = w_q; mark_wd = MarkOnPath;
          stk_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      node_count_q <= CountW'(1);
      edges_q <= '0;
      err_q <= 1'b0;
      clr_q <= '0;
      clr_after_q <= 1'b0;
      a_q <= '0;
      b_q <= '0;
      tail_a_q <= Nil;
      tail_b_q <= Nil;
      sp_q <= '0;
      reached_q <= '0;
      fnode_q <= '0;
      fpar_q <= '0;
      fhas_q <= 1'b0;
      fcur_q <= Nil;
      w_q <= '0;
      done_o <= 1'b0;
      is_tree_o <= 1'b0;
      verdict_o <= VerdictTree;
      nodes_reached_o <= '0;
      verdict_q <= VerdictTree;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      case (state_q)
        StClear: begin
          clr_q <= clr_q + NW'(1);
          if (32'(clr_q) == MaxNodes - 1) begin
            clr_q <= '0;
            edges_q <= '0;
            err_q <= 1'b0;
            if (clr_after_q) begin
              state_q <= StResult;
            end else begin
              state_q <= StIdle;
            end
          end
        end
        StIdle: begin
          if (start) begin
            a_q <= NW'(node_a_i);
            b_q <= NW'(node_b_i);
            if (kind_i) begin
              clr_after_q <= 1'b1;
              reached_q <= '0;
              if (err_q) begin
                verdict_q <= VerdictEdgeFail;
                state_q <= StClear;
              end else begin
                fnode_q <= '0; fpar_q <= '0; fhas_q <= 1'b0;
                sp_q <= SW'(1);
                state_q <= StRoot;
              end
            end else if (bad_edge) begin
              err_q <= 1'b1;
            end else begin
              state_q <= StEdgeA;
            end
          end
        end
        StEdgeA: begin
          tail_a_q <= tail_rd;
          state_q <= StEdgeLinkA;
        end
        StEdgeLinkA: begin
          tail_b_q <= tail_b;
          state_q <= StEdgeB;
        end
        StEdgeB: state_q <= StEdgeLinkB;
        StEdgeLinkB: begin
          edges_q <= edges_q + ECW'(1);
          state_q <= StIdle;
        end
        StRoot: state_q <= StRootW;
        StRootW: begin
          fcur_q <= head_rd;
          state_q <= StStep;
        end
        StStep: begin
          if (fcur_q == Nil) begin
            // pop the finished node
            reached_q <= reached_q + CW'(1);
            sp_q <= sp_m1;
            if (sp_m1 == '0) begin
              verdict_q <= ((32'(reached_q) + 32'd1) == 32'(node_count_q)) ?
                           VerdictTree : VerdictPartial;
              state_q <= StClear;
            end else begin
              state_q <= StPopW;
            end
          end else begin
            state_q <= StEntW;
          end
        end
        StEntW: begin
          w_q <= tgt_rd;
          fcur_q <= nxt_rd;
          // the way back to the parent is skipped, duplicates included
          if (fhas_q && tgt_rd == fpar_q) begin
            state_q <= StStep;
          end else begin
            state_q <= StMarkW;
          end
        end
        StMarkW: begin
          if (mark_rd == MarkOnPath) begin
            verdict_q <= VerdictCycle;
            state_q <= StClear;
          end else if (push_ok) begin
            fnode_q <= w_q;
            fpar_q <= fnode_q;
            fhas_q <= 1'b1;
            sp_q <= sp_q + SW'(1);
            state_q <= StHeadW;
          end else begin
            state_q <= StStep;
          end
        end
        StHeadW: begin
          fcur_q <= head_rd;
          state_q <= StStep;
        end
        StPopW: begin
          {fnode_q, fpar_q, fhas_q, fcur_q} <= stk_rd;
          state_q <= StStep;
        end
        StResult: begin
          done_o <= 1'b1;
          verdict_o <= verdict_q;
          is_tree_o <= (verdict_q == VerdictTree);
          nodes_reached_o <= (verdict_q == VerdictEdgeFail) ? '0 : CountW'(reached_q);
          clr_after_q <= 1'b0;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // checks
  a_busy_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without preceding work");
  a_tree_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_tree_o == (verdict_o == VerdictTree))) else $error("is_tree mismatch");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && verdict_o == VerdictEdgeFail) |-> (nodes_reached_o == '0))
    else $error("edge failure with reached count");
endmodule
`default_nettype wire

>>> test/testbench.sv
// testbench for graph_valid_tree_check: directed table, store-full run, random graphs,
// checked by a behavioral dfs predictor kept in step with every accepted transfer
// depends on gvtc_pkg and the checker rtl
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import gvtc_pkg::*;

  localparam int NoEntry   = -1;
  localparam int EdgeSlots = 2 * MaxEdgesDef;

  typedef enum logic [1:0] {RowEdge, RowCheck, RowCfg} row_op_e;

  // one row of the directed plan; fixed marks rows whose result is typed in
  typedef struct {
    row_op_e             op;
    int                  a;
    int                  b;
    bit                  fixed;
    logic [VerdictW-1:0] verdict;
    int                  reached;
  } plan_row_t;

  typedef struct packed {
    logic                is_tree;
    logic [VerdictW-1:0] verdict;
    logic [CountW-1:0]   reached;
  } tree_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                cfg_we_i = 1'b0;
  logic [CountW-1:0]   cfg_wdata_i = '0;
  logic                kind_i = 1'b0;
  logic [NodeW-1:0]    node_a_i = '0;
  logic [NodeW-1:0]    node_b_i = '0;
  logic                done_o;
  logic                is_tree_o;
  logic [VerdictW-1:0] verdict_o;
  logic [CountW-1:0]   nodes_reached_o;

  graph_valid_tree_check dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .kind_i         (kind_i),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .done_o         (done_o),
    .is_tree_o      (is_tree_o),
    .verdict_o      (verdict_o),
    .nodes_reached_o(nodes_reached_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // graph model: adjacency lists in insertion order, marks and the walk stack
  // ---------------------------------------------------------------------------
  int adj_target [EdgeSlots];
  int adj_next   [EdgeSlots];
  int adj_head   [MaxNodesDef];
  int adj_tail   [MaxNodesDef];
  logic [1:0] node_state [MaxNodesDef];
  int walk_node   [MaxNodesDef];
  int walk_parent [MaxNodesDef];
  bit walk_hasp   [MaxNodesDef];
  int walk_cursor [MaxNodesDef];
  int  model_nodes;   // shadow of the node_count register
  int  model_edges;
  bit  model_err;

  tree_result_t verdicts_due[$];
  bit failed = 1'b0;

  function automatic void graph_clear();
    for (int i = 0; i < MaxNodesDef; i++) begin
      adj_head[i] = NoEntry;
      adj_tail[i] = NoEntry;
      node_state[i] = MarkUnseen;
    end
    model_edges = 0;
    model_err = 1'b0;
  endfunction

  function automatic void list_append(int from, int to, int slot);
    adj_target[slot] = to;
    adj_next[slot] = NoEntry;
    if (adj_tail[from] == NoEntry) adj_head[from] = slot;
    else adj_next[adj_tail[from]] = slot;
    adj_tail[from] = slot;
  endfunction

  function automatic void graph_add(int a, int b);
    if (a >= model_nodes || b >= model_nodes || model_edges >= MaxEdgesDef) begin
      model_err = 1'b1;
    end else begin
      list_append(a, b, 2 * model_edges);
      list_append(b, a, 2 * model_edges + 1);
      model_edges++;
    end
  endfunction

  // dfs from node 0; a back edge to an on-path node other than the parent is a cycle
  function automatic tree_result_t graph_verdict();
    tree_result_t res;
    int sp;
    int top;
    int w;
    int reached;
    bit cycle;
    reached = 0;
    cycle = 1'b0;
    if (model_err) begin
      res.verdict = VerdictEdgeFail;
    end else begin
      node_state[0] = MarkOnPath;
      walk_node[0] = 0;
      walk_parent[0] = 0;
      walk_hasp[0] = 1'b0;
      walk_cursor[0] = adj_head[0];
      sp = 1;
      while (sp > 0 && !cycle) begin
        top = sp - 1;
        if (walk_cursor[top] == NoEntry) begin
          node_state[walk_node[top]] = MarkDone;
          reached++;
          sp--;
        end else begin
          w = adj_target[walk_cursor[top]];
          walk_cursor[top] = adj_next[walk_cursor[top]];
          if (!(walk_hasp[top] && w == walk_parent[top])) begin
            if (node_state[w] == MarkOnPath) begin
              cycle = 1'b1;
            end else if (node_state[w] == MarkUnseen && sp < MaxNodesDef) begin
              node_state[w] = MarkOnPath;
              walk_node[sp] = w;
              walk_parent[sp] = walk_node[top];
              walk_hasp[sp] = 1'b1;
              walk_cursor[sp] = adj_head[w];
              sp++;
            end
          end
        end
      end
      if (cycle) res.verdict = VerdictCycle;
      else if (reached == model_nodes) res.verdict = VerdictTree;
      else res.verdict = VerdictPartial;
    end
    res.is_tree = (res.verdict == VerdictTree);
    res.reached = CountW'(reached);
    graph_clear();
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking: every strobe must match the oldest pending verdict
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tree_result_t want;
    if (rst_ni && done_o) begin
      if (verdicts_due.size() == 0) begin
        $error("result with no pending check: verdict %0d reached %0d",
               verdict_o, nodes_reached_o);
        failed = 1'b1;
      end else begin
        want = verdicts_due.pop_front();
        if (is_tree_o !== want.is_tree) begin
          $error("is_tree: expected %0d, got %0d", want.is_tree, is_tree_o);
          failed = 1'b1;
        end
        if (verdict_o !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, verdict_o);
          failed = 1'b1;
        end
        if (nodes_reached_o !== want.reached) begin
          $error("nodes_reached: expected %0d, got %0d", want.reached, nodes_reached_o);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender: bursts of back-to-back transfers separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int items_sent = 0;

  task automatic send_item(bit is_check, int a, int b, bit fixed = 1'b0,
                           logic [VerdictW-1:0] fixed_verdict = VerdictTree,
                           int fixed_reached = 0);
    tree_result_t res;
    int gap;
    @(negedge clk_i);
    start <= 1'b1;
    kind_i <= is_check;
    node_a_i <= NodeW'(a);
    node_b_i <= NodeW'(b);
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (is_check) begin
      res = graph_verdict();
      if (fixed) begin
        res.verdict = fixed_verdict;
        res.is_tree = (fixed_verdict == VerdictTree);
        res.reached = CountW'(fixed_reached);
      end
      verdicts_due = {verdicts_due, res};
    end else begin
      graph_add(a, b);
    end
    // burst bookkeeping; a new burst now and then has no gap at all
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // pause until every pending verdict has come and the block is idle again
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (verdicts_due.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_node_count(int value);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CountW'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    model_nodes = value;
  endtask

  // ---------------------------------------------------------------------------
  // directed plan: reset value, self-loop, bad endpoints, duplicate parent edge,
  // cycle, unreached nodes, zero and oversized node counts
  // ---------------------------------------------------------------------------
  localparam int PlanRows = 28;
  plan_row_t plan [PlanRows] = '{
    '{RowCheck, 0, 0, 1'b1, VerdictTree, 1},         // lone node 0 is a tree
    '{RowEdge, 0, 0, 1'b0, VerdictTree, 0},          // self-loop
    '{RowCheck, 0, 0, 1'b1, VerdictCycle, 0},
    '{RowEdge, 0, 1, 1'b0, VerdictTree, 0},          // endpoint at node_count
    '{RowCheck, 0, 0, 1'b1, VerdictEdgeFail, 0},
    '{RowEdge, 255, 255, 1'b0, VerdictTree, 0},      // top endpoint values
    '{RowCheck, 0, 0, 1'b1, VerdictEdgeFail, 0},
    '{RowCfg, 4, 0, 1'b0, VerdictTree, 0},
    '{RowEdge, 0, 1, 1'b0, VerdictTree, 0},
    '{RowEdge, 0, 1, 1'b0, VerdictTree, 0},          // duplicate of parent edge
    '{RowEdge, 1, 2, 1'b0, VerdictTree, 0},
    '{RowEdge, 2, 3, 1'b0, VerdictTree, 0},
    '{RowCheck, 0, 0, 1'b0, VerdictTree, 0},
    '{RowEdge, 0, 1, 1'b0, VerdictTree, 0},
    '{RowEdge, 1, 2, 1'b0, VerdictTree, 0},
    '{RowEdge, 2, 0, 1'b0, VerdictTree, 0},          // triangle
    '{RowEdge, 0, 3, 1'b0, VerdictTree, 0},
    '{RowCheck, 0, 0, 1'b0, VerdictTree, 0},
    '{RowEdge, 1, 0, 1'b0, VerdictTree, 0},
    '{RowCheck, 0, 0, 1'b1, VerdictPartial, 2},      // nodes 2 and 3 isolated
    '{RowCfg, 0, 0, 1'b0, VerdictTree, 0},
    '{RowCheck, 0, 0, 1'b1, VerdictPartial, 1},      // zero node count
    '{RowCfg, 256, 0, 1'b0, VerdictTree, 0},
    '{RowEdge, 255, 0, 1'b0, VerdictTree, 0},
    '{RowCheck, 0, 0, 1'b0, VerdictTree, 0},
    '{RowCfg, 511, 0, 1'b0, VerdictTree, 0},
    '{RowCheck, 0, 0, 1'b1, VerdictPartial, 1},      // oversized node count
    '{RowCfg, 256, 0, 1'b0, VerdictTree, 0}
  };

  // one random graph: mostly a spanning tree, then maybe broken in one way
  task automatic send_random_graph();
    int label [MaxNodesDef];
    int ea[$];
    int eb[$];
    int n;
    int flavor;
    int j;
    int t;
    n = (model_nodes > MaxNodesDef) ? MaxNodesDef : model_nodes;
    flavor = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) label[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = label[i]; label[i] = label[j]; label[j] = t;
    end
    for (int v = 1; v < n; v++) begin
      j = label[$urandom_range(0, v - 1)];
      if ($urandom_range(0, 1) == 0) begin
        ea = {ea, label[v]}; eb = {eb, j};
      end else begin
        ea = {ea, j}; eb = {eb, label[v]};
      end
    end
    case (flavor)
      5: begin
        // extra edge closes a cycle or adds a self-loop
        if (n > 0) begin
          ea = {ea, int'($urandom_range(0, n - 1))};
          eb = {eb, int'($urandom_range(0, n - 1))};
        end
      end
      6: begin
        // drop one edge so part of the graph is unreachable
        if (ea.size() > 0) begin
          j = $urandom_range(0, ea.size() - 1);
          ea.delete(j); eb.delete(j);
        end
      end
      7: begin
        // endpoint out of range
        if (model_nodes <= 255) begin
          ea = {ea, int'($urandom_range(model_nodes, 255))};
          eb = {eb, int'($urandom_range(0, 255))};
        end
      end
      8: begin
        // repeat an existing edge, possibly reversed
        if (ea.size() > 0) begin
          j = $urandom_range(0, ea.size() - 1);
          ea = {ea, eb[j]}; eb = {eb, ea[j]};
        end
      end
      9: begin
        // noise: random edges with no structure
        ea.delete(); eb.delete();
        repeat ($urandom_range(0, 10)) begin
          ea = {ea, int'($urandom_range(0, 255) % (n > 0 ? n + 1 : 256))};
          eb = {eb, int'($urandom_range(0, 255))};
        end
      end
      default: ;
    endcase
    for (int i = ea.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = ea[i]; ea[i] = ea[j]; ea[j] = t;
      t = eb[i]; eb[i] = eb[j]; eb[j] = t;
    end
    foreach (ea[i]) send_item(1'b0, ea[i], eb[i]);
    send_item(1'b1, $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  initial begin
    int big_left;
    int pick;
    model_nodes = 1;
    graph_clear();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      case (plan[i].op)
        RowCfg:   write_node_count(plan[i].a);
        RowEdge:  send_item(1'b0, plan[i].a, plan[i].b);
        default:  send_item(1'b1, 0, 0, plan[i].fixed, plan[i].verdict, plan[i].reached);
      endcase
    end

    // store full: one edge past capacity is dropped and flagged
    for (int i = 0; i <= MaxEdgesDef; i++) send_item(1'b0, i % 200, (i * 7 + 1) % 200);
    send_item(1'b1, 0, 0, 1'b1, VerdictEdgeFail, 0);

    items_sent = 0;
    big_left = 2;
    while (items_sent < 400) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0 && big_left > 0) begin
          big_left--;
          write_node_count(256);
        end else if (pick == 1) begin
          write_node_count(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(257, 511));
        end else if (pick == 2) begin
          write_node_count(1);
        end else begin
          write_node_count($urandom_range(2, 16));
        end
      end else if (model_nodes > 64) begin
        write_node_count($urandom_range(2, 16));
      end
      send_random_graph();
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (!failed && verdicts_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
